/* src/gc3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gc3_pkg;

  // Result and configuration port widths
  localparam int GRAD_W      = 19;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int FW_W        = 11;
  localparam int FH_W        = 16;
  localparam int COEF_W      = 8;

  // Output queue sizing
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  // Register reset values
  localparam logic [FW_W-1:0]          FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]          FRAME_HEIGHT_RST = 16'd480;
  localparam logic signed [COEF_W-1:0] COEF_OUTER_A_RST = 8'sd1;
  localparam logic signed [COEF_W-1:0] COEF_MIDDLE_RST  = 8'sd2;
  localparam logic signed [COEF_W-1:0] COEF_OUTER_B_RST = 8'sd1;
  localparam logic                     DIRECTION_RST    = 1'b1;

  // Input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Gradient direction codes
  localparam logic DIR_VERTICAL   = 1'b0;
  localparam logic DIR_HORIZONTAL = 1'b1;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_OUTER_A = 3'd2,
    REG_COEF_MIDDLE  = 3'd3,
    REG_COEF_OUTER_B = 3'd4,
    REG_DIRECTION    = 3'd5
  } cfg_reg_t;

  // Per-item control that travels with the pixel into the datapath
  typedef struct packed {
    logic emit;    // item produces a result
    logic last;    // result closes the frame
    logic top;     // upper window row lies outside the frame
    logic bottom;  // lower window row lies outside the frame
    logic left;    // left window column lies outside the frame
    logic right;   // right window column lies outside the frame
  } gc3_flags_t;

endpackage

`default_nettype wire

/* src/gc3_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module gc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic                           re,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr,
  output logic      [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read at the written address returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/gc3_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module gc3_datapath import gc3_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic [PIXEL_BITS-1:0]           upper,
  input  wire logic [PIXEL_BITS-1:0]           lower,
  input  wire logic [PIXEL_BITS-1:0]           pixel,
  input  wire gc3_flags_t                      flags,
  input  wire logic signed [COEF_W-1:0]        coef_outer_a,
  input  wire logic signed [COEF_W-1:0]        coef_middle,
  input  wire logic signed [COEF_W-1:0]        coef_outer_b,
  input  wire logic                            direction,
  output logic                                 res_valid,
  output logic signed [GRAD_W-1:0]             res_gradient,
  output logic                                 res_last
);

  localparam int DIFF_W = PIXEL_BITS + 1;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int SUM_W  = (PROD_W + 2 > GRAD_W) ? PROD_W + 2 : GRAD_W;

  logic [PIXEL_BITS-1:0]    win      [3][3];
  logic [PIXEL_BITS-1:0]    win_next [3][3];
  logic [PIXEL_BITS-1:0]    tap      [3][3];
  logic [PIXEL_BITS-1:0]    minuend  [3];
  logic [PIXEL_BITS-1:0]    subtra   [3];
  logic signed [DIFF_W-1:0] diff     [3];
  logic signed [COEF_W-1:0] coef     [3];
  logic signed [PROD_W-1:0] c_prod   [3];
  logic                     c_valid;
  logic                     c_last;
  logic signed [SUM_W-1:0]  sum_wide;

  // Shift the window left and load the new column: upper, lower, incoming
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = upper;
    win_next[1][2] = lower;
    win_next[2][2] = pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (in_valid) begin
      win <= win_next;
    end
  end

  // Zero the taps that fall outside the frame
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && flags.top) || (r == 2 && flags.bottom) ||
            (c == 0 && flags.left) || (c == 2 && flags.right)) begin
          tap[r][c] = '0;
        end else begin
          tap[r][c] = win_next[r][c];
        end
      end
    end
  end

  // Pick the tap pairs: left minus right column, or lower minus upper row
  always_comb begin
    if (direction == DIR_HORIZONTAL) begin
      minuend[0] = tap[2][0]; subtra[0] = tap[2][2];
      minuend[1] = tap[1][0]; subtra[1] = tap[1][2];
      minuend[2] = tap[0][0]; subtra[2] = tap[0][2];
    end else begin
      minuend[0] = tap[2][0]; subtra[0] = tap[0][0];
      minuend[1] = tap[2][1]; subtra[1] = tap[0][1];
      minuend[2] = tap[2][2]; subtra[2] = tap[0][2];
    end
    coef[0] = coef_outer_a;
    coef[1] = coef_middle;
    coef[2] = coef_outer_b;
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({1'b0, minuend[k]}) - $signed({1'b0, subtra[k]});
    end
  end

  // Register the three weighted differences
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= in_valid && flags.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && flags.emit) begin
      c_last <= flags.last;
      for (int k = 0; k < 3; k++) begin
        c_prod[k] <= coef[k] * diff[k];
      end
    end
  end

  // Add the products and wrap to the result width
  assign sum_wide     = SUM_W'(c_prod[0]) + SUM_W'(c_prod[1]) + SUM_W'(c_prod[2]);
  assign res_gradient = $signed(sum_wide[GRAD_W-1:0]);
  assign res_valid    = c_valid;
  assign res_last     = c_last;

endmodule

`default_nettype wire

/* src/gradient_conv_3x3_top.sv */
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  in       | sink      | in_valid / in_stall  | cmd, pixel
//  out      | source    | out_valid / out_stall| gradient, frame_last
//  cfg      | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle unless stalled; the line store is a single read-modify-write
//  memory (one read on acceptance, write-back in the next cycle, with a bypass).
//  A result passes the line store stage, product registers and output queue.
//  Reset (rst, synchronous) restores the register defaults and clears the window.
//  The line store needs no clearing pass: entries not yet written are masked.
//  in_stall rises only when four results are in flight or queued under out_stall.
`timescale 1ns / 1ps
`default_nettype none

module gradient_conv_3x3_top import gc3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        cmd,
  input  wire logic [PIXEL_BITS-1:0]       pixel,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [GRAD_W-1:0]         gradient,
  output logic                             frame_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  // Configuration registers
  logic [FW_W-1:0]          frame_width;
  logic [FH_W-1:0]          frame_height;
  logic signed [COEF_W-1:0] coef_outer_a;
  logic signed [COEF_W-1:0] coef_middle;
  logic signed [COEF_W-1:0] coef_outer_b;
  logic                     direction;
  logic                     cfg_xfer;
  logic                     size_write;

  // Frame position
  logic [CW-1:0] col_count;
  logic [FH_W-1:0] row_count;
  logic [CW-1:0] ccol;
  logic [FH_W-1:0] crow;
  logic          drained;

  logic [WW-1:0]   eff_w;
  logic [WW-1:0]   w_last;
  logic [FH_W-1:0] eff_h;
  logic [FH_W-1:0] h_last;
  logic            in_xfer;
  logic            restart;
  logic            pixel_phase;
  logic            drop;
  logic            take;
  logic [CW-1:0]   col_e;
  logic [FH_W-1:0] row_e;
  logic [CW-1:0]   ccol_e;
  logic [FH_W-1:0] crow_e;
  logic            col_wrap;
  logic [CW-1:0]   col_next;
  logic [FH_W-1:0] row_next;
  logic [CW-1:0]   ccol_next;
  logic [FH_W-1:0] crow_next;
  logic [PIXEL_BITS-1:0] pix_e;
  gc3_flags_t      flags_e;

  // Line store stage
  logic                    b_valid;
  logic [CW-1:0]           b_col;
  logic [PIXEL_BITS-1:0]   b_pix;
  gc3_flags_t              b_flags;
  logic                    b_byp;
  logic [2*PIXEL_BITS-1:0] b_byp_data;
  logic [2*PIXEL_BITS-1:0] ram_rdata;
  logic [2*PIXEL_BITS-1:0] line_rd;
  logic [2*PIXEL_BITS-1:0] line_wr;

  // Datapath result and output queue
  logic                    res_valid;
  logic signed [GRAD_W-1:0] res_gradient;
  logic                    res_last;
  logic [GRAD_W-1:0]       fifo_grad [FIFO_DEPTH];
  logic                    fifo_last [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   fill;
  logic [FIFO_CNT_W-1:0]   credits;
  logic                    out_xfer;

  // Configuration write port
  assign cfg_ready  = 1'b1;
  assign cfg_xfer   = cfg_valid && cfg_ready;
  assign size_write = cfg_xfer &&
                      (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      coef_outer_a <= COEF_OUTER_A_RST;
      coef_middle  <= COEF_MIDDLE_RST;
      coef_outer_b <= COEF_OUTER_B_RST;
      direction    <= DIRECTION_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        REG_COEF_OUTER_A: coef_outer_a <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_MIDDLE:  coef_middle  <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_OUTER_B: coef_outer_b <= $signed(cfg_data[COEF_W-1:0]);
        REG_DIRECTION:    direction    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to what the line store holds; a zero size counts as one
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    w_last = eff_w - 1'b1;
    eff_h  = (frame_height == '0) ? FH_W'(1) : frame_height;
    h_last = eff_h - 1'b1;
  end

  // Decide the fate of an incoming item and advance the frame position
  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    restart     = drained && (cmd == CMD_PIXEL);
    col_e       = restart ? '0 : col_count;
    row_e       = restart ? '0 : row_count;
    ccol_e      = restart ? '0 : ccol;
    crow_e      = restart ? '0 : crow;
    pixel_phase = row_e < eff_h;
    drop        = drained ? (cmd == CMD_FLUSH) : (pixel_phase && cmd == CMD_FLUSH);
    take        = in_xfer && !drop;
    pix_e       = pixel_phase ? pixel : '0;

    col_wrap = (WW'(col_e) == w_last);
    col_next = col_wrap ? '0 : col_e + 1'b1;
    row_next = (col_wrap && row_e != '1) ? row_e + 1'b1 : row_e;

    flags_e.emit   = (row_e >= FH_W'(2)) || (row_e == FH_W'(1) && col_e != '0);
    flags_e.top    = (crow_e == '0);
    flags_e.bottom = (crow_e >= h_last);
    flags_e.left   = (ccol_e == '0);
    flags_e.right  = (WW'(ccol_e) >= w_last);
    flags_e.last   = flags_e.bottom && flags_e.right;

    ccol_next = flags_e.right ? '0 : ccol_e + 1'b1;
    crow_next = flags_e.right ? crow_e + 1'b1 : crow_e;
  end

  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      col_count <= '0;
      row_count <= '0;
      ccol      <= '0;
      crow      <= '0;
      drained   <= 1'b0;
    end else if (take) begin
      col_count <= col_next;
      row_count <= row_next;
      if (flags_e.emit) begin
        ccol    <= ccol_next;
        crow    <= crow_next;
        drained <= flags_e.last;
      end else begin
        ccol    <= ccol_e;
        crow    <= crow_e;
        drained <= 1'b0;
      end
    end
  end

  // Read the line store column on acceptance, write it back in the next cycle
  assign line_rd = b_byp ? b_byp_data : ram_rdata;
  assign line_wr = {line_rd[PIXEL_BITS-1:0], b_pix};

  gc3_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata (line_wr),
    .re    (take),
    .raddr (col_e),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= take;
    end
  end

  // Hold the item and bypass a write-back that races the read of the same column
  always_ff @(posedge clk) begin
    if (take) begin
      b_col      <= col_e;
      b_pix      <= pix_e;
      b_flags    <= flags_e;
      b_byp      <= b_valid && (b_col == col_e);
      b_byp_data <= line_wr;
    end
  end

  gc3_datapath #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (b_valid),
    .upper        (line_rd[2*PIXEL_BITS-1:PIXEL_BITS]),
    .lower        (line_rd[PIXEL_BITS-1:0]),
    .pixel        (b_pix),
    .flags        (b_flags),
    .coef_outer_a (coef_outer_a),
    .coef_middle  (coef_middle),
    .coef_outer_b (coef_outer_b),
    .direction    (direction),
    .res_valid    (res_valid),
    .res_gradient (res_gradient),
    .res_last     (res_last)
  );

  // Count results in flight and queued; stall input when the queue could overflow
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = (credits == FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + FIFO_CNT_W'(take && flags_e.emit) - FIFO_CNT_W'(out_xfer);
    end
  end

  // Output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + FIFO_CNT_W'(res_valid) - FIFO_CNT_W'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_grad[wr_ptr] <= res_gradient;
      fifo_last[wr_ptr] <= res_last;
    end
  end

  assign out_valid  = (fill != '0);
  assign gradient   = $signed(fifo_grad[rd_ptr]);
  assign frame_last = fifo_last[rd_ptr];

endmodule

`default_nettype wire

/* src/gc3_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module gc3_checker import gc3_pkg::*; (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic signed [GRAD_W-1:0]    gradient,
  input wire logic                        frame_last
);

  // Hold a stalled result
  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(gradient) && $stable(frame_last))
    else $error("result payload changed while stalled");

  // Input backpressure only arises from queued results
  a_stall_backed: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // Leave reset with an empty pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind gradient_conv_3x3_top gc3_checker u_checker (.*);

`default_nettype wire

/* sim/gc3_grad_checker.sv */
`timescale 1ns / 1ps

module gc3_grad_checker import gc3_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     cmd,
  input  logic [7:0]               pixel,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [GRAD_W-1:0] gradient,
  input  logic                     frame_last,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       fails,
  output int                       outstanding
);

  localparam int LINE_LEN = 1024;
  localparam int SHOWN    = 10;

  typedef struct {
    logic signed [GRAD_W-1:0] gradient;
    logic                     frame_last;
  } grad_result_t;

  grad_result_t expected_grads[$];

  // Shadow of the datapath: two line stores, the 3x3 window, raster counters
  logic [7:0]      upper_line [LINE_LEN];
  logic [7:0]      lower_line [LINE_LEN];
  logic [7:0]      win [3][3];
  int unsigned     col_pos;
  int unsigned     row_pos;
  int unsigned     done_cnt;

  // Shadow of the register file
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  int              coef_a;
  int              coef_m;
  int              coef_b;
  logic            dir_reg;

  int              mismatches = 0;

  function automatic int unsigned active_width();
    if (width_reg == '0) return 1;
    if (width_reg > LINE_LEN) return LINE_LEN;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == '0) ? 1 : height_reg;
  endfunction

  task automatic restart_frame();
    col_pos  = 0;
    row_pos  = 0;
    done_cnt = 0;
  endtask

  task automatic reset_model();
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    foreach (win[r, k]) win[r][k] = '0;
    restart_frame();
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    coef_a     = int'(COEF_OUTER_A_RST);
    coef_m     = int'(COEF_MIDDLE_RST);
    coef_b     = int'(COEF_OUTER_B_RST);
    dir_reg    = DIRECTION_RST;
  endtask

  // Size writes abandon the frame in progress; the rest act at once
  task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      REG_FRAME_WIDTH: begin
        width_reg = data[FW_W-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data[FH_W-1:0];
        restart_frame();
      end
      REG_COEF_OUTER_A: coef_a = int'($signed(data[COEF_W-1:0]));
      REG_COEF_MIDDLE:  coef_m = int'($signed(data[COEF_W-1:0]));
      REG_COEF_OUTER_B: coef_b = int'($signed(data[COEF_W-1:0]));
      REG_DIRECTION:    dir_reg = data[0];
      default: ;
    endcase
  endtask

  // Advance the window by one item and queue the gradient it releases, if any
  task automatic convolve_item(input logic item_cmd, input logic [7:0] pix);
    int unsigned  w;
    int unsigned  h;
    int unsigned  total;
    int unsigned  lc;
    int unsigned  crow;
    int unsigned  ccol;
    logic [7:0]   a;
    logic [7:0]   b;
    logic [7:0]   v;
    logic         live;
    logic         emit;
    logic         masked;
    int           p [3][3];
    int           sum;
    grad_result_t res;

    w     = active_width();
    h     = active_height();
    total = w * h;
    live  = (row_pos < h);

    // Drained frame: a flush is dropped, a pixel opens the next frame
    if (done_cnt >= total) begin
      if (item_cmd == CMD_FLUSH) return;
      restart_frame();
      live = 1'b1;
    end else if (live && item_cmd == CMD_FLUSH) begin
      return;
    end

    // Pixels after the last row arrived are treated as flush ticks
    v  = live ? pix : 8'd0;
    lc = col_pos % LINE_LEN;
    a  = upper_line[lc];
    b  = lower_line[lc];
    upper_line[lc] = b;
    lower_line[lc] = v;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = a;
    win[1][2] = b;
    win[2][2] = v;

    emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos < 32'hFFFF) row_pos++;
    end

    if (!emit) return;

    // Zero the neighbors that fall outside the frame
    crow = done_cnt / w;
    ccol = done_cnt % w;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        masked = (r == 0 && crow == 0) || (r == 2 && crow + 1 >= h) ||
                 (k == 0 && ccol == 0) || (k == 2 && ccol + 1 >= w);
        p[r][k] = masked ? 0 : int'(win[r][k]);
      end
    end

    if (dir_reg == DIR_HORIZONTAL) begin
      sum = coef_a * (p[2][0] - p[2][2]) + coef_m * (p[1][0] - p[1][2]) +
            coef_b * (p[0][0] - p[0][2]);
    end else begin
      sum = coef_a * (p[2][0] - p[0][0]) + coef_m * (p[2][1] - p[0][1]) +
            coef_b * (p[2][2] - p[0][2]);
    end

    done_cnt++;
    res.gradient   = GRAD_W'(sum);
    res.frame_last = (done_cnt == total);
    expected_grads.push_back(res);
  endtask

  // Watch all three channels at each edge and compare outgoing transfers
  always @(posedge clk) begin : watch
    grad_result_t want;
    if (rst) begin
      reset_model();
      expected_grads.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_config(cfg_index, cfg_data);
      if (in_valid && !in_stall) convolve_item(cmd, pixel);
      if (out_valid && !out_stall) begin
        if (expected_grads.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN)
            $display("%0t: unexpected result gradient %0d frame_last %0b",
                     $realtime, gradient, frame_last);
        end else begin
          want = expected_grads.pop_front();
          if (want.gradient !== gradient || want.frame_last !== frame_last) begin
            mismatches++;
            if (mismatches <= SHOWN)
              $display("%0t: mismatch gradient exp %0d got %0d, frame_last exp %0b got %0b",
                       $realtime, want.gradient, gradient, want.frame_last, frame_last);
          end
        end
      end
    end
    fails       <= mismatches;
    outstanding <= expected_grads.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import gc3_pkg::*;

  localparam int ITEMS      = 1000;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 8;
  localparam int TAIL       = 16;

  // Index past the register map; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     cmd       = CMD_PIXEL;
  logic [7:0]               pixel     = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data  = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic signed [GRAD_W-1:0] gradient;
  logic                     frame_last;
  logic                     cfg_ready;
  int                       fails;
  int                       outstanding;

  logic                     calm        = 1'b0;
  int                       stall_left  = 0;
  int                       idle_cycles = 0;
  int                       cur_w       = 1;
  int                       cur_h       = 1;
  logic                     frame_open  = 1'b0;

  logic [7:0] ramp_x [6] = '{8'd255, 8'd128, 8'd0, 8'd255, 8'd1, 8'd0};
  logic [7:0] ramp_y [6] = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255};

  gradient_conv_3x3_top uut (.*);

  gc3_grad_checker checker_i (.*);

  always #2 clk = ~clk;

  // Receiver: hold off for a random number of cycles after each transfer
  always @(posedge clk) begin : out_pacing
    int n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      n = calm ? 0 : $urandom_range(0, 9);
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Drop the run when no channel has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_pixel();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input logic [FW_W-1:0] w_raw, input logic [FH_W-1:0] h_raw);
    cfg_write(REG_FRAME_WIDTH, {5'($urandom_range(0, 31)), w_raw});
    cfg_write(REG_FRAME_HEIGHT, h_raw);
    cur_w      = (w_raw == '0) ? 1 : (w_raw > 1024) ? 1024 : int'(w_raw);
    cur_h      = (h_raw == '0) ? 1 : int'(h_raw);
    frame_open = 1'b0;
  endtask

  // Keep valid high across back-to-back items; lower it only for a gap
  task automatic send(input logic c, input logic [7:0] p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    pixel    <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
  endtask

  // Push out the last row: one item per column plus one; some are stray pixels
  task automatic send_tail(inout int counted);
    repeat (cur_w + 1) begin
      send(($urandom_range(0, 4) == 0) ? CMD_PIXEL : CMD_FLUSH, rand_pixel());
      counted++;
    end
  endtask

  initial begin : stimulus
    int              counted;
    int              n;
    int              k;
    logic [FW_W-1:0] w_raw;
    logic [FH_W-1:0] h_raw;

    counted = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Small x frame with extreme coefficients and pixels
    cfg_write(REG_UNMAPPED, 16'($urandom));
    set_size(11'd3, 16'd2);
    cfg_write(REG_COEF_OUTER_A, 16'h0080);
    cfg_write(REG_COEF_MIDDLE, 16'h007F);
    cfg_write(REG_COEF_OUTER_B, 16'h0001);
    cfg_write(REG_DIRECTION, {15'h0, DIR_HORIZONTAL});
    send(CMD_FLUSH, 8'hA5);
    foreach (ramp_x[i]) send(CMD_PIXEL, ramp_x[i]);
    send(CMD_PIXEL, 8'd200);
    repeat (3) send(CMD_FLUSH, 8'h5A);
    send(CMD_FLUSH, 8'hFF);

    // Same size in y mode: the first pixel reopens the drained frame
    settle();
    cfg_write(REG_COEF_OUTER_A, 16'hFF7F);
    cfg_write(REG_COEF_MIDDLE, 16'h0080);
    cfg_write(REG_COEF_OUTER_B, 16'h007F);
    cfg_write(REG_DIRECTION, {15'h7FFF, DIR_VERTICAL});
    foreach (ramp_y[i]) send(CMD_PIXEL, ramp_y[i]);
    repeat (4) send(CMD_FLUSH, 8'($urandom));

    // Zero width and height act as one
    settle();
    set_size(11'd0, 16'd0);
    send(CMD_PIXEL, 8'hFF);
    repeat (2) send(CMD_FLUSH, 8'h00);

    // Tall frame, abandoned part way by the next size write
    settle();
    set_size(11'd3, 16'hFFFF);
    repeat (7) send(CMD_PIXEL, rand_pixel());
    frame_open = 1'b1;
    settle();

    // One frame at the widest setting
    cfg_write(REG_DIRECTION, {15'h0, DIR_HORIZONTAL});
    set_size(11'($urandom_range(1024, 2047)), 16'd1);
    repeat (cur_w) send(CMD_PIXEL, rand_pixel());
    send_tail(n);

    // Random frames of random content, with occasional reconfiguration
    while (counted < ITEMS) begin
      calm <= ($urandom_range(0, 3) == 0);
      if (frame_open || $urandom_range(0, 99) < 35) begin
        settle();
        if ($urandom_range(0, 1)) cfg_write(REG_COEF_OUTER_A, 16'($urandom));
        if ($urandom_range(0, 1)) cfg_write(REG_COEF_MIDDLE, 16'($urandom));
        if ($urandom_range(0, 1)) cfg_write(REG_COEF_OUTER_B, 16'($urandom));
        if ($urandom_range(0, 1)) cfg_write(REG_DIRECTION, 16'($urandom));
        if ($urandom_range(0, 19) == 0) cfg_write(REG_UNMAPPED, 16'($urandom));
        if (frame_open || $urandom_range(0, 2) == 0) begin
          k = $urandom_range(0, 99);
          if (k < 4)       w_raw = '0;
          else if (k < 14) w_raw = 11'($urandom_range(9, 48));
          else             w_raw = 11'($urandom_range(1, 8));
          h_raw = ($urandom_range(0, 24) == 0) ? '0 : 16'($urandom_range(1, 5));
          set_size(w_raw, h_raw);
        end
      end

      n = cur_w * cur_h;
      if (n > 1 && $urandom_range(0, 9) == 0) begin
        // Broken frame: stop short and leave it for a size write to discard
        repeat ($urandom_range(1, n - 1)) begin
          send(CMD_PIXEL, rand_pixel());
          counted++;
        end
        frame_open = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 19) == 0) send(CMD_FLUSH, rand_pixel());
          send(CMD_PIXEL, rand_pixel());
          counted++;
          if (i == n / 2 && $urandom_range(0, 7) == 0) hold_until_drained();
        end
        send_tail(counted);
        if ($urandom_range(0, 9) == 0) send(CMD_FLUSH, rand_pixel());
      end
    end

    hold_until_drained();
    repeat (TAIL) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* gradient_conv_3x3_top.f */
src/gc3_pkg.sv
src/gc3_ram.sv
src/gc3_datapath.sv
src/gradient_conv_3x3_top.sv
src/gc3_checker.sv
sim/gc3_grad_checker.sv
sim/tb.sv
